// ===== hw/rtl/nvmeq_pkg.sv =====
// ----------------------------------------------------------------------------
// nvmeq_pkg
// Shared types, codes and limits of the NVMe I/O queue pair engine.
// ----------------------------------------------------------------------------
package nvmeq_pkg;

  localparam int unsigned QUEUE_SLOTS_DEF    = 64;
  localparam int unsigned MAX_TRANSFER_BYTES = 2097152;
  localparam int unsigned LIST_ENTRIES       = 512;
  localparam int unsigned PAGE_BYTES         = 4096;

  // Configuration register indexes.
  localparam logic [1:0] CFG_QUEUE_DEPTH   = 2'd0;
  localparam logic [1:0] CFG_NAMESPACE_ID  = 2'd1;
  localparam logic [1:0] CFG_CAPACITY      = 2'd2;
  localparam logic [1:0] CFG_PRP_LIST_BASE = 2'd3;

  // Request operations.
  localparam logic OPN_SUBMIT   = 1'b0;
  localparam logic OPN_COMPLETE = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_SUBMIT    = 2'd0;
  localparam logic [1:0] KIND_DELIVERED = 2'd1;
  localparam logic [1:0] KIND_UNKNOWN   = 2'd2;
  localparam logic [1:0] KIND_NOT_READY = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_INVALID = 2'd1;
  localparam logic [1:0] ERR_NO_ID   = 2'd2;
  localparam logic [1:0] ERR_DEVICE  = 2'd3;

  // Command opcodes.
  localparam logic [1:0] OPC_NONE  = 2'd0;
  localparam logic [1:0] OPC_WRITE = 2'd1;
  localparam logic [1:0] OPC_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  error_code;
    logic [5:0]  command_id;
    logic [1:0]  opcode;
    logic [31:0] prp_entry_one;
    logic [31:0] prp_entry_two;
    logic [11:0] block_count_minus_one;
    logic [9:0]  list_page_count;
    logic [31:0] list_first_page;
    logic [5:0]  queue_index;
    logic [15:0] returned_tag;
    logic [63:0] command_sector;
  } result_t;

  // Slot table operations: set, clear and read; a clear may come with a read.
  typedef struct packed {
    logic set;
    logic clr;
    logic rd;
  } slot_op_t;

endpackage

// ===== hw/rtl/nvmeq_slots.sv =====
// ----------------------------------------------------------------------------
// nvmeq_slots
// Command id table: busy flags cleared by reset and a host tag memory.
// ----------------------------------------------------------------------------
module nvmeq_slots #(
  parameter int unsigned QUEUE_SLOTS = nvmeq_pkg::QUEUE_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  nvmeq_pkg::slot_op_t            op,
  input  logic [$clog2(QUEUE_SLOTS)-1:0] idx,
  input  logic [15:0]                    wr_tag,
  output logic                           busy,
  output logic [15:0]                    rd_tag_r
);

  logic [QUEUE_SLOTS-1:0] busy_r;
  logic [15:0]            tag_mem [QUEUE_SLOTS];

  assign busy = busy_r[idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else if (op.set) begin
      busy_r[idx] <= 1'b1;
    end else if (op.clr) begin
      busy_r[idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op.set) begin
      tag_mem[idx] <= wr_tag;
    end
    if (op.rd) begin
      rd_tag_r <= tag_mem[idx];
    end
  end

endmodule

// ===== hw/rtl/nvme_io_queue_engine.sv =====
// ----------------------------------------------------------------------------
// nvme_io_queue_engine
// Submit: input checks, a scan of one busy flag per cycle for the lowest free
// command id, command build, tail step. Completion: slot read, head step. A
// failed input check or stale phase goes straight to the result. A pointer is
// stepped to zero by subtracting the depth, more than once only past a lowered
// depth. A new request is taken the cycle after the result is registered.
// Synchronous active-low reset clears busy flags and pointers, loads defaults.
// ----------------------------------------------------------------------------
module nvme_io_queue_engine #(
  parameter int unsigned QUEUE_SLOTS = nvmeq_pkg::QUEUE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // Requests
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic        in_is_write,
  input  logic [63:0] in_start_sector,
  input  logic [23:0] in_length_bytes,
  input  logic [31:0] in_data_address,
  input  logic [15:0] in_request_tag,
  input  logic [15:0] in_entry_status,
  input  logic [15:0] in_entry_command_id,
  // Results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [1:0]  out_error_code,
  output logic [5:0]  out_command_id,
  output logic [1:0]  out_opcode,
  output logic [31:0] out_prp_entry_one,
  output logic [31:0] out_prp_entry_two,
  output logic [11:0] out_block_count_minus_one,
  output logic [9:0]  out_list_page_count,
  output logic [31:0] out_list_first_page,
  output logic [5:0]  out_queue_index,
  output logic [15:0] out_returned_tag,
  output logic [63:0] out_command_sector
);

  localparam int unsigned ID_W    = $clog2(QUEUE_SLOTS);
  localparam int unsigned DEPTH_W = $clog2(QUEUE_SLOTS + 1);
  localparam int unsigned CMP_W   = (DEPTH_W > 7) ? DEPTH_W : 7;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_BUILD,
    S_CPL,
    S_WRAP,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers. The namespace id belongs to the built command
  // but no result field carries it.
  logic [6:0]  qdepth_r;
  logic [31:0] nsid_r;
  logic [63:0] capacity_r;
  logic [31:0] list_base_r;

  // Queue state.
  logic [ID_W-1:0] tail_r, tail_nxt;
  logic [ID_W-1:0] head_r, head_nxt;
  logic            phase_r, phase_nxt;

  // Request being worked on.
  logic            op_r, op_nxt;
  logic            wr_r, wr_nxt;
  logic [63:0]     sector_r, sector_nxt;
  logic [23:0]     len_r, len_nxt;
  logic [31:0]     addr_r, addr_nxt;
  logic [15:0]     tag_r, tag_nxt;
  logic [15:0]     ecid_r, ecid_nxt;
  logic [ID_W-1:0] cid_r, cid_nxt;
  logic            hit_r, hit_nxt;

  // Sequencer counters: free id scan, and the pointer step shared by tail and head.
  logic [DEPTH_W-1:0] scan_cnt_r, scan_cnt_nxt;
  logic [DEPTH_W-1:0] wrap_val_r, wrap_val_nxt;

  nvmeq_pkg::result_t res_r, res_nxt;
  nvmeq_pkg::result_t out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Slot table port.
  nvmeq_pkg::slot_op_t slot_op;
  logic [ID_W-1:0]     slot_idx;
  logic                slot_busy;
  logic [15:0]         slot_rd_tag;

  nvmeq_slots #(
    .QUEUE_SLOTS(QUEUE_SLOTS)
  ) u_slots (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (slot_op),
    .idx     (slot_idx),
    .wr_tag  (tag_r),
    .busy    (slot_busy),
    .rd_tag_r(slot_rd_tag)
  );

  // Effective depth, clamped to 2..QUEUE_SLOTS.
  logic [CMP_W-1:0]   qd_ext;
  logic [CMP_W-1:0]   depth_cmp;
  logic [DEPTH_W-1:0] depth;

  always_comb begin
    qd_ext = CMP_W'(qdepth_r);
    if (qd_ext < CMP_W'(2)) begin
      depth_cmp = CMP_W'(2);
    end else if (qd_ext > CMP_W'(QUEUE_SLOTS)) begin
      depth_cmp = CMP_W'(QUEUE_SLOTS);
    end else begin
      depth_cmp = qd_ext;
    end
    depth = depth_cmp[DEPTH_W-1:0];
  end

  // Zero-extended views of id-wide values, ID_W+6 bits wide.
  logic [ID_W+5:0] tail_ext, head_ext, wrap_ext, cid_ext;

  assign tail_ext = (ID_W + 6)'(tail_r);
  assign head_ext = (ID_W + 6)'(head_r);
  assign wrap_ext = (ID_W + 6)'(wrap_val_r[ID_W-1:0]);
  assign cid_ext  = (ID_W + 6)'(cid_r);

  // Submit checks on the incoming request.
  logic [14:0] in_sectors;
  logic        len_bad, cap_bad, sub_bad;

  always_comb begin
    in_sectors = in_length_bytes[23:9];
    len_bad = (in_length_bytes == 24'd0) || (in_length_bytes[8:0] != 9'd0) ||
              (in_length_bytes > 24'(nvmeq_pkg::MAX_TRANSFER_BYTES)) ||
              (in_data_address == 32'd0);
    cap_bad = (in_start_sector > capacity_r) ||
              (64'(in_sectors) > (capacity_r - in_start_sector));
    sub_bad = len_bad || cap_bad;
  end

  // PRP layout of the latched request.
  logic [12:0] first_raw;
  logic [23:0] first_len, left_len;
  logic [31:0] next_page;
  logic [24:0] pages_sum;
  logic [12:0] pages;
  logic [14:0] sectors_m1;
  logic        need_list;
  logic [31:0] list_addr;

  always_comb begin
    first_raw = 13'(nvmeq_pkg::PAGE_BYTES) - {1'b0, addr_r[11:0]};
    first_len = (24'(first_raw) > len_r) ? len_r : 24'(first_raw);
    left_len  = len_r - first_len;
    next_page = (addr_r + 32'(first_len) + 32'h0000_0FFF) & 32'hFFFF_F000;
    pages_sum = {1'b0, left_len} + 25'h0000FFF;
    pages     = pages_sum[24:12];
    need_list = left_len > 24'(nvmeq_pkg::PAGE_BYTES);
    list_addr = list_base_r + 32'({cid_r, 12'h000});
    sectors_m1 = len_r[23:9] - 15'd1;
  end

  // Completion id range check.
  logic cid_in_range;
  assign cid_in_range = ecid_r < 16'(depth);

  always_comb begin
    state_nxt     = state_r;
    tail_nxt      = tail_r;
    head_nxt      = head_r;
    phase_nxt     = phase_r;
    op_nxt        = op_r;
    wr_nxt        = wr_r;
    sector_nxt    = sector_r;
    len_nxt       = len_r;
    addr_nxt      = addr_r;
    tag_nxt       = tag_r;
    ecid_nxt      = ecid_r;
    cid_nxt       = cid_r;
    hit_nxt       = hit_r;
    scan_cnt_nxt  = scan_cnt_r;
    wrap_val_nxt  = wrap_val_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    slot_op       = '0;
    slot_idx      = cid_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_operation;
          wr_nxt     = in_is_write;
          sector_nxt = in_start_sector;
          len_nxt    = in_length_bytes;
          addr_nxt   = in_data_address;
          tag_nxt    = in_request_tag;
          ecid_nxt   = in_entry_command_id;
          res_nxt    = '0;
          if (in_operation == nvmeq_pkg::OPN_SUBMIT) begin
            res_nxt.result_kind = nvmeq_pkg::KIND_SUBMIT;
            res_nxt.queue_index = tail_ext[5:0];
            if (sub_bad) begin
              res_nxt.error_code = nvmeq_pkg::ERR_INVALID;
              state_nxt          = S_DONE;
            end else begin
              scan_cnt_nxt = '0;
              state_nxt    = S_SCAN;
            end
          end else if (in_entry_status[0] != phase_r) begin
            res_nxt.result_kind = nvmeq_pkg::KIND_NOT_READY;
            res_nxt.queue_index = head_ext[5:0];
            state_nxt           = S_DONE;
          end else begin
            res_nxt.error_code = (in_entry_status[15:1] != 15'd0) ?
                                 nvmeq_pkg::ERR_DEVICE : nvmeq_pkg::ERR_OK;
            state_nxt = S_CPL;
          end
        end
      end

      S_SCAN: begin
        slot_idx = scan_cnt_r[ID_W-1:0];
        if (scan_cnt_r == depth) begin
          res_nxt.error_code = nvmeq_pkg::ERR_NO_ID;
          state_nxt          = S_DONE;
        end else if (!slot_busy) begin
          cid_nxt   = scan_cnt_r[ID_W-1:0];
          state_nxt = S_BUILD;
        end else begin
          scan_cnt_nxt = scan_cnt_r + DEPTH_W'(1);
        end
      end

      S_BUILD: begin
        if (need_list && (pages > 13'(nvmeq_pkg::LIST_ENTRIES))) begin
          res_nxt.error_code = nvmeq_pkg::ERR_INVALID;
          state_nxt          = S_DONE;
        end else begin
          slot_op.set                   = 1'b1;
          res_nxt.command_id            = cid_ext[5:0];
          res_nxt.opcode                = wr_r ? nvmeq_pkg::OPC_WRITE : nvmeq_pkg::OPC_READ;
          res_nxt.prp_entry_one         = addr_r;
          res_nxt.block_count_minus_one = sectors_m1[11:0];
          res_nxt.command_sector        = sector_r;
          if (need_list) begin
            res_nxt.prp_entry_two   = list_addr;
            res_nxt.list_page_count = pages[9:0];
            res_nxt.list_first_page = next_page;
          end else if (left_len != 24'd0) begin
            res_nxt.prp_entry_two = next_page;
          end
          wrap_val_nxt = DEPTH_W'(tail_r) + DEPTH_W'(1);
          state_nxt    = S_WRAP;
        end
      end

      S_CPL: begin
        slot_idx     = ecid_r[ID_W-1:0];
        slot_op.rd   = 1'b1;
        slot_op.clr  = cid_in_range && slot_busy;
        hit_nxt      = cid_in_range && slot_busy;
        wrap_val_nxt = DEPTH_W'(head_r) + DEPTH_W'(1);
        state_nxt    = S_WRAP;
      end

      S_WRAP: begin
        // Reduce the stepped pointer modulo the depth, one subtract a cycle.
        if (wrap_val_r >= depth) begin
          wrap_val_nxt = wrap_val_r - depth;
        end else begin
          res_nxt.queue_index = wrap_ext[5:0];
          if (op_r == nvmeq_pkg::OPN_SUBMIT) begin
            tail_nxt = wrap_val_r[ID_W-1:0];
          end else begin
            head_nxt = wrap_val_r[ID_W-1:0];
            if (wrap_val_r == '0) begin
              phase_nxt = !phase_r;
            end
            if (hit_r) begin
              res_nxt.result_kind  = nvmeq_pkg::KIND_DELIVERED;
              res_nxt.command_id   = ecid_r[5:0];
              res_nxt.returned_tag = slot_rd_tag;
            end else begin
              res_nxt.result_kind = nvmeq_pkg::KIND_UNKNOWN;
            end
          end
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tail_r      <= '0;
      head_r      <= '0;
      phase_r     <= 1'b1;
      out_valid_r <= 1'b0;
      qdepth_r    <= 7'd64;
      nsid_r      <= 32'd1;
      capacity_r  <= 64'd0;
      list_base_r <= 32'd0;
    end else begin
      state_r     <= state_nxt;
      tail_r      <= tail_nxt;
      head_r      <= head_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          nvmeq_pkg::CFG_QUEUE_DEPTH:   qdepth_r    <= cfg_data[6:0];
          nvmeq_pkg::CFG_NAMESPACE_ID:  nsid_r      <= cfg_data[31:0];
          nvmeq_pkg::CFG_CAPACITY:      capacity_r  <= cfg_data;
          nvmeq_pkg::CFG_PRP_LIST_BASE: list_base_r <= cfg_data[31:0];
          default:                      qdepth_r    <= qdepth_r;
        endcase
      end
    end
    op_r       <= op_nxt;
    wr_r       <= wr_nxt;
    sector_r   <= sector_nxt;
    len_r      <= len_nxt;
    addr_r     <= addr_nxt;
    tag_r      <= tag_nxt;
    ecid_r     <= ecid_nxt;
    cid_r      <= cid_nxt;
    hit_r      <= hit_nxt;
    scan_cnt_r <= scan_cnt_nxt;
    wrap_val_r <= wrap_val_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end

  assign in_stall                  = (state_r != S_IDLE);
  assign out_valid                 = out_valid_r;
  assign out_result_kind           = out_r.result_kind;
  assign out_error_code            = out_r.error_code;
  assign out_command_id            = out_r.command_id;
  assign out_opcode                = out_r.opcode;
  assign out_prp_entry_one         = out_r.prp_entry_one;
  assign out_prp_entry_two         = out_r.prp_entry_two;
  assign out_block_count_minus_one = out_r.block_count_minus_one;
  assign out_list_page_count       = out_r.list_page_count;
  assign out_list_first_page       = out_r.list_first_page;
  assign out_queue_index           = out_r.queue_index;
  assign out_returned_tag          = out_r.returned_tag;
  assign out_command_sector        = out_r.command_sector;

`ifndef SYNTH
  // The expected phase flips only when the completion head wraps to zero.
  a_phase_on_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(phase_r) |-> head_r == '0)
    else $error("phase toggled without head wrap");

  // An accepted submit always carries a built command.
  a_submit_opcode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == nvmeq_pkg::KIND_SUBMIT &&
    out_error_code == nvmeq_pkg::ERR_OK |-> out_opcode != nvmeq_pkg::OPC_NONE)
    else $error("accepted submit without opcode");

  // The free id scan never runs past the queue depth.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> scan_cnt_r <= depth)
    else $error("free id scan beyond depth");

  // A finished result is registered as soon as the output side is free.
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && (!out_valid_r || !out_stall) |=> out_valid_r && state_r == S_IDLE)
    else $error("finished result not presented");
`endif

endmodule

// ===== tb/nvmeq_result_checker.sv =====
// ----------------------------------------------------------------------------
// nvmeq_result_checker
// Watches the request, result and register ports of the queue pair engine,
// keeps its own copy of the slot table, ring pointers and registers, predicts
// the result of every accepted request and compares each accepted result
// with the oldest prediction. Mismatches are counted for the testbench top.
// ----------------------------------------------------------------------------
module nvmeq_result_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_operation,
  input  logic               in_is_write,
  input  logic [63:0]        in_start_sector,
  input  logic [23:0]        in_length_bytes,
  input  logic [31:0]        in_data_address,
  input  logic [15:0]        in_request_tag,
  input  logic [15:0]        in_entry_status,
  input  logic [15:0]        in_entry_command_id,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         out_result_kind,
  input  logic [1:0]         out_error_code,
  input  logic [5:0]         out_command_id,
  input  logic [1:0]         out_opcode,
  input  logic [31:0]        out_prp_entry_one,
  input  logic [31:0]        out_prp_entry_two,
  input  logic [11:0]        out_block_count_minus_one,
  input  logic [9:0]         out_list_page_count,
  input  logic [31:0]        out_list_first_page,
  input  logic [5:0]         out_queue_index,
  input  logic [15:0]        out_returned_tag,
  input  logic [63:0]        out_command_sector,
  output int unsigned        fail_count,
  output int unsigned        in_flight,
  output logic [63:0]        busy_ids,
  output logic               cq_phase
);

  localparam int unsigned SLOT_LIMIT = 64;
  localparam logic [31:0] PAGE_OFFSET = 32'(nvmeq_pkg::PAGE_BYTES - 1);

  typedef struct packed {
    logic        operation;
    logic        is_write;
    logic [63:0] sector;
    logic [23:0] length;
    logic [31:0] address;
    logic [15:0] tag;
    logic [15:0] status;
    logic [15:0] entry_id;
  } request_t;

  logic [6:0]  depth_reg;
  logic [31:0] nsid_reg;
  logic [63:0] capacity_reg;
  logic [31:0] list_base_reg;

  logic [63:0] busy;
  logic [15:0] tag_of [SLOT_LIMIT];
  logic [5:0]  sq_tail;
  logic [5:0]  cq_head;
  logic        phase;

  nvmeq_pkg::result_t due_results [$];
  int unsigned        mismatches = 0;

  assign fail_count = mismatches;

  function automatic int unsigned ring_depth();
    int unsigned d;
    d = depth_reg;
    if (d < 2) d = 2;
    if (d > SLOT_LIMIT) d = SLOT_LIMIT;
    return d;
  endfunction

  function automatic nvmeq_pkg::result_t build_command(input request_t r,
                                                       input int unsigned depth);
    nvmeq_pkg::result_t res;
    int unsigned        sectors;
    int unsigned        cid;
    int unsigned        first;
    int unsigned        left;
    int unsigned        pages;
    int                 i;
    logic [31:0]        next_page;
    res = '0;
    res.result_kind = nvmeq_pkg::KIND_SUBMIT;
    res.queue_index = sq_tail;
    if (r.length == 0 || r.length[8:0] != 0 || r.length > nvmeq_pkg::MAX_TRANSFER_BYTES ||
        r.address == 0) begin
      res.error_code = nvmeq_pkg::ERR_INVALID;
      return res;
    end
    sectors = r.length >> 9;
    if (sectors > 65536 || r.sector > capacity_reg ||
        64'(sectors) > capacity_reg - r.sector) begin
      res.error_code = nvmeq_pkg::ERR_INVALID;
      return res;
    end
    cid = depth;
    for (i = int'(depth) - 1; i >= 0; i--) begin
      if (!busy[i]) cid = i;
    end
    if (cid == depth) begin
      res.error_code = nvmeq_pkg::ERR_NO_ID;
      return res;
    end
    first = nvmeq_pkg::PAGE_BYTES - int'(r.address & PAGE_OFFSET);
    if (first > r.length) first = r.length;
    left = r.length - first;
    // Page addresses wrap at 4 GiB, so the sum stays 32 bits wide.
    next_page = (r.address + 32'(first) + PAGE_OFFSET) & ~PAGE_OFFSET;
    pages = 0;
    if (left > nvmeq_pkg::PAGE_BYTES) begin
      pages = (left + nvmeq_pkg::PAGE_BYTES - 1) / nvmeq_pkg::PAGE_BYTES;
      if (pages > nvmeq_pkg::LIST_ENTRIES) begin
        res.error_code = nvmeq_pkg::ERR_INVALID;
        return res;
      end
      res.list_first_page = next_page;
      res.prp_entry_two = list_base_reg + 32'(cid * nvmeq_pkg::PAGE_BYTES);
    end else if (left > 0) begin
      res.prp_entry_two = next_page;
    end
    tag_of[cid] = r.tag;
    busy[cid] = 1'b1;
    sq_tail = 6'((int'(sq_tail) + 1) % depth);
    res.command_id = 6'(cid);
    res.opcode = r.is_write ? nvmeq_pkg::OPC_WRITE : nvmeq_pkg::OPC_READ;
    res.prp_entry_one = r.address;
    res.block_count_minus_one = 12'(sectors - 1);
    res.list_page_count = 10'(pages);
    res.queue_index = sq_tail;
    res.command_sector = r.sector;
    return res;
  endfunction

  function automatic nvmeq_pkg::result_t retire_entry(input request_t r,
                                                      input int unsigned depth);
    nvmeq_pkg::result_t res;
    res = '0;
    if (r.status[0] != phase) begin
      res.result_kind = nvmeq_pkg::KIND_NOT_READY;
      res.queue_index = cq_head;
      return res;
    end
    res.error_code = (r.status[15:1] != 0) ? nvmeq_pkg::ERR_DEVICE : nvmeq_pkg::ERR_OK;
    if (r.entry_id < depth && busy[r.entry_id[5:0]]) begin
      busy[r.entry_id[5:0]] = 1'b0;
      res.result_kind = nvmeq_pkg::KIND_DELIVERED;
      res.command_id = r.entry_id[5:0];
      res.returned_tag = tag_of[r.entry_id[5:0]];
    end else begin
      res.result_kind = nvmeq_pkg::KIND_UNKNOWN;
    end
    // The head still moves for an unknown id; the phase flips on each wrap.
    cq_head = 6'((int'(cq_head) + 1) % depth);
    if (cq_head == 0) phase = ~phase;
    res.queue_index = cq_head;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    request_t           req;
    nvmeq_pkg::result_t seen;
    nvmeq_pkg::result_t want;
    if (!rst_n) begin
      depth_reg = 7'd64;
      nsid_reg = 32'd1;
      capacity_reg = '0;
      list_base_reg = '0;
      busy = '0;
      foreach (tag_of[i]) tag_of[i] = '0;
      sq_tail = '0;
      cq_head = '0;
      phase = 1'b1;
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen = {out_result_kind, out_error_code, out_command_id, out_opcode,
                out_prp_entry_one, out_prp_entry_two, out_block_count_minus_one,
                out_list_page_count, out_list_first_page, out_queue_index,
                out_returned_tag, out_command_sector};
        if (due_results.size() == 0) begin
          $error("result with no request waiting: kind %0h", out_result_kind);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("result_kind", want.result_kind, seen.result_kind);
          check_field("error_code", want.error_code, seen.error_code);
          check_field("command_id", want.command_id, seen.command_id);
          check_field("opcode", want.opcode, seen.opcode);
          check_field("prp_entry_one", want.prp_entry_one, seen.prp_entry_one);
          check_field("prp_entry_two", want.prp_entry_two, seen.prp_entry_two);
          check_field("block_count_minus_one", want.block_count_minus_one,
                      seen.block_count_minus_one);
          check_field("list_page_count", want.list_page_count, seen.list_page_count);
          check_field("list_first_page", want.list_first_page, seen.list_first_page);
          check_field("queue_index", want.queue_index, seen.queue_index);
          check_field("returned_tag", want.returned_tag, seen.returned_tag);
          check_field("command_sector", want.command_sector, seen.command_sector);
        end
      end
      if (in_valid && !in_stall) begin
        req = {in_operation, in_is_write, in_start_sector, in_length_bytes,
               in_data_address, in_request_tag, in_entry_status, in_entry_command_id};
        if (req.operation == nvmeq_pkg::OPN_SUBMIT) begin
          due_results.push_back(build_command(req, ring_depth()));
        end else begin
          due_results.push_back(retire_entry(req, ring_depth()));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          nvmeq_pkg::CFG_QUEUE_DEPTH:   depth_reg = cfg_data[6:0];
          nvmeq_pkg::CFG_NAMESPACE_ID:  nsid_reg = cfg_data[31:0];
          nvmeq_pkg::CFG_CAPACITY:      capacity_reg = cfg_data;
          nvmeq_pkg::CFG_PRP_LIST_BASE: list_base_reg = cfg_data[31:0];
          default: ;
        endcase
      end
    end
    in_flight <= due_results.size();
    busy_ids <= busy;
    cq_phase <= phase;
  end

endmodule

// ===== tb/tb_nvme_io_queue_engine.sv =====
// ----------------------------------------------------------------------------
// tb_nvme_io_queue_engine
// Drives the queue pair engine with a short directed set of submit and
// completion requests, then with random phases under changing register
// settings, random idling on both channels and one long result hold-off.
// A checker beside the engine predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_nvme_io_queue_engine;

  localparam int unsigned DRAIN_CYCLES    = 150;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned LONG_HOLD       = 600;
  localparam int unsigned MAX_GAP         = 18;
  localparam int unsigned RAND_PHASES     = 8;
  localparam int unsigned ITEMS_PER_PHASE = 125;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        in_operation;
  logic        in_is_write;
  logic [63:0] in_start_sector;
  logic [23:0] in_length_bytes;
  logic [31:0] in_data_address;
  logic [15:0] in_request_tag;
  logic [15:0] in_entry_status;
  logic [15:0] in_entry_command_id;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_result_kind;
  logic [1:0]  out_error_code;
  logic [5:0]  out_command_id;
  logic [1:0]  out_opcode;
  logic [31:0] out_prp_entry_one;
  logic [31:0] out_prp_entry_two;
  logic [11:0] out_block_count_minus_one;
  logic [9:0]  out_list_page_count;
  logic [31:0] out_list_first_page;
  logic [5:0]  out_queue_index;
  logic [15:0] out_returned_tag;
  logic [63:0] out_command_sector;

  int unsigned fail_count;
  int unsigned in_flight;
  logic [63:0] busy_ids;
  logic        cq_phase;

  bit          calm = 1'b0;
  bit          hold_long = 1'b0;
  int unsigned depth_set = 64;
  logic [63:0] capacity_set = '0;

  nvme_io_queue_engine u_dut (.*);

  nvmeq_result_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: random stalls before each result, none while calm, one long hold.
  initial begin : result_sink
    int unsigned n;
    bit          held;
    held = 1'b0;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_long && !held) begin
        n = LONG_HOLD;
        held = 1'b1;
      end else begin
        n = calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic pace_sender();
    int unsigned n;
    n = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic present(input logic op, input logic wr, input logic [63:0] sector,
                         input logic [23:0] len, input logic [31:0] addr,
                         input logic [15:0] tag, input logic [15:0] status,
                         input logic [15:0] cid);
    in_operation <= op;
    in_is_write <= wr;
    in_start_sector <= sector;
    in_length_bytes <= len;
    in_data_address <= addr;
    in_request_tag <= tag;
    in_entry_status <= status;
    in_entry_command_id <= cid;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic submit(input logic wr, input logic [63:0] sector, input logic [23:0] len,
                        input logic [31:0] addr);
    pace_sender();
    present(nvmeq_pkg::OPN_SUBMIT, wr, sector, len, addr, 16'($urandom), 16'($urandom),
            16'($urandom));
  endtask

  task automatic complete(input logic [15:0] status, input logic [15:0] cid);
    pace_sender();
    present(nvmeq_pkg::OPN_COMPLETE, 1'($urandom), rand64(), 24'($urandom), $urandom,
            16'($urandom), status, cid);
  endtask

  task automatic random_submit();
    logic [63:0] sector;
    logic [23:0] len;
    logic [31:0] addr;
    int unsigned nsec;
    int unsigned pick;
    pace_sender();
    pick = $urandom_range(0, 99);
    if (pick < 70) nsec = $urandom_range(1, 24);
    else if (pick < 90) nsec = $urandom_range(1, 4096);
    else nsec = $urandom_range(3968, 4096);
    len = 24'(nsec * 512);
    addr = $urandom;
    if ($urandom_range(0, 3) == 0) addr[11:0] = '0;
    if (addr == 0) addr = 32'(nvmeq_pkg::PAGE_BYTES);
    if (capacity_set >= nsec) begin
      sector = rand64() % (capacity_set - 64'(nsec) + 64'd1);
    end else begin
      sector = rand64();
    end
    // A small share of malformed requests.
    pick = $urandom_range(0, 99);
    if (pick < 6) len = 24'($urandom);
    else if (pick < 9) sector = rand64();
    else if (pick < 11) addr = '0;
    present(nvmeq_pkg::OPN_SUBMIT, 1'($urandom), sector, len, addr, 16'($urandom),
            16'($urandom), 16'($urandom));
  endtask

  task automatic random_completion();
    logic [15:0] status;
    logic [15:0] cid;
    int unsigned start;
    int unsigned i;
    int unsigned pick;
    pace_sender();
    status = {15'd0, cq_phase};
    if ($urandom_range(0, 3) == 0) status[15:1] = 15'($urandom);
    start = $urandom_range(0, depth_set - 1);
    cid = 16'(start);
    for (i = 0; i < depth_set; i++) begin
      if (busy_ids[(start + i) % depth_set]) begin
        cid = 16'((start + i) % depth_set);
        break;
      end
    end
    pick = $urandom_range(0, 99);
    if (pick < 8) cid = 16'($urandom);
    else if (pick < 14) status[0] = ~status[0];
    present(nvmeq_pkg::OPN_COMPLETE, 1'($urandom), rand64(), 24'($urandom), $urandom,
            16'($urandom), status, cid);
  endtask

  // Waits until every request has its result and the engine has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_queue(input logic [6:0] depth, input logic [31:0] nsid,
                               input logic [63:0] capacity, input logic [31:0] base);
    logic [63:0] junk;
    junk = rand64();
    cfg_we <= 1'b1;
    cfg_index <= nvmeq_pkg::CFG_QUEUE_DEPTH;
    cfg_data <= {junk[63:7], depth};
    @(posedge clk);
    cfg_index <= nvmeq_pkg::CFG_NAMESPACE_ID;
    cfg_data <= {junk[31:0], nsid};
    @(posedge clk);
    cfg_index <= nvmeq_pkg::CFG_CAPACITY;
    cfg_data <= capacity;
    @(posedge clk);
    cfg_index <= nvmeq_pkg::CFG_PRP_LIST_BASE;
    cfg_data <= {junk[63:32], base};
    @(posedge clk);
    cfg_we <= 1'b0;
    depth_set = (depth < 2) ? 2 : (depth > 64) ? 64 : depth;
    capacity_set = capacity;
  endtask

  initial begin : stimulus
    int unsigned share;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= nvmeq_pkg::CFG_QUEUE_DEPTH;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_operation <= nvmeq_pkg::OPN_SUBMIT;
    in_is_write <= 1'b0;
    in_start_sector <= '0;
    in_length_bytes <= '0;
    in_data_address <= '0;
    in_request_tag <= '0;
    in_entry_status <= '0;
    in_entry_command_id <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: zero capacity rejects every submit.
    submit(1'b0, 64'd0, 24'd512, 32'h0000_1000);
    settle();
    program_queue(7'd64, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_F000);
    submit(1'b1, 64'd0, 24'd512, 32'h0000_0001);
    // Full-size transfers: aligned, and unaligned with address wrap.
    submit(1'b0, 64'd1000, 24'h20_0000, 32'h0000_1000);
    submit(1'b1, 64'hFFFF_FFFF_FFFF_EFFF, 24'h20_0000, 32'hFFFF_FE00);
    submit(1'b0, 64'd5, 24'd4096, 32'h0000_0801);
    submit(1'b1, 64'd7, 24'd8192, 32'h0000_4000);
    submit(1'b0, 64'd7, 24'd8704, 32'h0000_4000);
    submit(1'b1, 64'd0, 24'd0, 32'h0000_1000);
    submit(1'b0, 64'd0, 24'd511, 32'h0000_1000);
    submit(1'b1, 64'd0, 24'h20_0200, 32'h0000_1000);
    submit(1'b0, 64'd0, 24'hFF_FFFF, 32'hFFFF_FFFF);
    submit(1'b1, 64'd0, 24'd512, 32'h0000_0000);
    submit(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 24'd512, 32'h0000_2000);
    submit(1'b1, 64'hFFFF_FFFF_FFFF_FFFE, 24'd512, 32'hFFFF_FFFF);
    complete(16'h0001, 16'd0);
    complete(16'hFFFF, 16'd1);
    complete(16'h0001, 16'd0);
    complete(16'h0001, 16'hFFFF);
    complete(16'h0000, 16'd2);
    settle();
    // Lowered depth leaves both pointers beyond the ring and few free ids.
    program_queue(7'd2, 32'h0000_0000, 64'd100, 32'h0000_0000);
    submit(1'b1, 64'd99, 24'd512, 32'h0000_3000);
    submit(1'b0, 64'd0, 24'd51200, 32'h0000_3000);
    submit(1'b1, 64'd0, 24'd512, 32'h0000_3000);
    complete(16'h0001, 16'd0);
    complete(16'h0001, 16'd1);
    settle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: program_queue(7'd64, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_F000);
        1: program_queue(7'd2, 32'hFFFF_FFFF, 64'd300, 32'h0);
        2: program_queue(7'd127, $urandom, rand64(), $urandom);
        3: program_queue(7'd8, $urandom, 64'd5000, 32'h0000_1000);
        4: program_queue(7'd0, $urandom, 64'hFFFF_FFFF_FFFF_FFFF, $urandom);
        5: program_queue(7'd33, $urandom, 64'd0, $urandom);
        6: program_queue(7'd1, $urandom, 64'd1_000_000, 32'hFFFF_FFFF);
        default: program_queue(7'd64, 32'h1, 64'hFFFF_FFFF_FFFF_FFFF, $urandom);
      endcase
      // Hold results back long enough that the engine stalls new requests.
      if (p == 2) hold_long = 1'b1;
      share = $urandom_range(35, 70);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k % 25 == 0) calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < share) random_submit();
        else random_completion();
      end
      calm = 1'b0;
      settle();
    end

    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/nvmeq_pkg.sv
hw/rtl/nvmeq_slots.sv
hw/rtl/nvme_io_queue_engine.sv
tb/nvmeq_result_checker.sv
tb/tb_nvme_io_queue_engine.sv
